>>> design/md5_pkg.sv
// md5_pkg: shared constants, types and round tables for the MD5 digest engine.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package md5_pkg;
	localparam int LenBitsDefault = 64;
	localparam int QueueDepth = 4;
	localparam logic [31:0] IvA = 32'h67452301;
	localparam logic [31:0] IvB = 32'hEFCDAB89;
	localparam logic [31:0] IvC = 32'h98BADCFE;
	localparam logic [31:0] IvD = 32'h10325476;
	localparam logic [7:0] PadByte = 8'b10000000;
	localparam logic [5:0] LenPos = 6'd56;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       is_last;
		logic       no_byte;
	} item_t;

	function automatic logic [31:0] round_k(input logic [5:0] r);
		logic [31:0] k;
		case (r)
			6'd0: k = 32'hd76aa478; 6'd1: k = 32'he8c7b756; 6'd2: k = 32'h242070db;
			6'd3: k = 32'hc1bdceee; 6'd4: k = 32'hf57c0faf; 6'd5: k = 32'h4787c62a;
			6'd6: k = 32'ha8304613; 6'd7: k = 32'hfd469501; 6'd8: k = 32'h698098d8;
			6'd9: k = 32'h8b44f7af; 6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
			6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193; 6'd14: k = 32'ha679438e;
			6'd15: k = 32'h49b40821; 6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
			6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa; 6'd20: k = 32'hd62f105d;
			6'd21: k = 32'h02441453; 6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
			6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6; 6'd26: k = 32'hf4d50d87;
			6'd27: k = 32'h455a14ed; 6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
			6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a; 6'd32: k = 32'hfffa3942;
			6'd33: k = 32'h8771f681; 6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
			6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9; 6'd38: k = 32'hf6bb4b60;
			6'd39: k = 32'hbebfbc70; 6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
			6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05; 6'd44: k = 32'hd9d4d039;
			6'd45: k = 32'he6db99e5; 6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
			6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97; 6'd50: k = 32'hab9423a7;
			6'd51: k = 32'hfc93a039; 6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
			6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1; 6'd56: k = 32'h6fa87e4f;
			6'd57: k = 32'hfe2ce6e0; 6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
			6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235; 6'd62: k = 32'h2ad7d2bb;
			default: k = 32'heb86d391;
		endcase
		return k;
	endfunction

	function automatic logic [4:0] round_s(input logic [5:0] r);
		logic [4:0] s;
		case ({r[5:4], r[1:0]})
			4'b0000: s = 5'd7;  4'b0001: s = 5'd12; 4'b0010: s = 5'd17; 4'b0011: s = 5'd22;
			4'b0100: s = 5'd5;  4'b0101: s = 5'd9;  4'b0110: s = 5'd14; 4'b0111: s = 5'd20;
			4'b1000: s = 5'd4;  4'b1001: s = 5'd11; 4'b1010: s = 5'd16; 4'b1011: s = 5'd23;
			4'b1100: s = 5'd6;  4'b1101: s = 5'd10; 4'b1110: s = 5'd15;
			default: s = 5'd21;
		endcase
		return s;
	endfunction

	function automatic logic [3:0] round_g(input logic [5:0] r);
		logic [3:0] g;
		case (r[5:4])
			2'd0: g = r[3:0];
			2'd1: g = 4'(r[3:0] * 4'd5 + 4'd1);
			2'd2: g = 4'(r[3:0] * 4'd3 + 4'd5);
			default: g = 4'(r[3:0] * 4'd7);
		endcase
		return g;
	endfunction

	function automatic logic [31:0] swap32(input logic [31:0] x);
		return {x[7:0], x[15:8], x[23:16], x[31:24]};
	endfunction
endpackage
`default_nettype wire

>>> design/md5_queue.sv
// md5_queue: small FIFO between the input front and the compression back end.
// Depends on md5_pkg.
`timescale 1ns / 1ps
`default_nettype none
module md5_queue #(
	parameter int DEPTH = md5_pkg::QueueDepth
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          wr,
	input  md5_pkg::item_t     wdata,
	output logic               full,
	input  wire logic          rd,
	output md5_pkg::item_t     rdata,
	output logic               empty
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	md5_pkg::item_t mem_q [DEPTH];
	logic [AW-1:0] wp_q, rp_q;
	logic [AW:0] cnt_q;

	assign full = (cnt_q == (AW+1)'(DEPTH));
	assign empty = (cnt_q == '0);
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr && !full) mem_q[wp_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (wr && !full) wp_q <= (wp_q == AW'(DEPTH-1)) ? '0 : wp_q + 1'b1;
			if (rd && !empty) rp_q <= (rp_q == AW'(DEPTH-1)) ? '0 : rp_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(wr && !full) - (AW+1)'(rd && !empty);
		end
	end
endmodule
`default_nettype wire

>>> design/md5_core.sv
// md5_core: block buffer, padding sequencer and one-round-per-cycle compression.
// Depends on md5_pkg.
`timescale 1ns / 1ps
`default_nettype none
module md5_core #(
	parameter int LEN_BITS = md5_pkg::LenBitsDefault
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  md5_pkg::item_t   item,
	input  wire logic        item_valid,
	output logic             item_take,
	output logic [63:0]      digest_part,
	output logic             part_last,
	output logic             empty,
	input  wire logic        pop
);
	localparam logic [2:0] StIdle = 3'd0, StRound = 3'd1, StPad = 3'd2, StLen = 3'd3,
		StOut0 = 3'd4, StOut1 = 3'd5;

	logic [2:0] state_q;
	logic [31:0] blk_q [16];
	logic [31:0] chain_q [4];
	logic [31:0] a_q, b_q, c_q, d_q;
	logic [60:0] count_q;
	logic [5:0] pos_q, round_q;
	logic fin_q;      // compressing a final block
	logic second_q;   // another padding block still to come
	logic item_pend_last_q;
	logic [63:0] bits;
	logic [31:0] f, t, rot, kt;
	logic [4:0] s;

	always_comb begin
		bits = {count_q, 3'b000};
		if (LEN_BITS < 64) bits = bits & ((64'd1 << LEN_BITS) - 64'd1);
		unique case (round_q[5:4])
			2'd0: f = (b_q & c_q) | (~b_q & d_q);
			2'd1: f = (b_q & d_q) | (c_q & ~d_q);
			2'd2: f = b_q ^ c_q ^ d_q;
			default: f = c_q ^ (b_q | ~d_q);
		endcase
		kt = md5_pkg::round_k(round_q);
		s = md5_pkg::round_s(round_q);
		t = f + a_q + kt + blk_q[md5_pkg::round_g(round_q)];
		rot = (t << s) | (t >> (6'd32 - {1'b0, s}));
	end

	assign item_take = (state_q == StIdle) && item_valid;
	assign empty = !(state_q == StOut0 || state_q == StOut1);
	assign part_last = (state_q == StOut1);
	assign digest_part = part_last ?
		{md5_pkg::swap32(chain_q[2]), md5_pkg::swap32(chain_q[3])} :
		{md5_pkg::swap32(chain_q[0]), md5_pkg::swap32(chain_q[1])};

	function automatic logic [31:0] put(input logic [31:0] w, input logic [1:0] lane,
		input logic [7:0] v);
		logic [31:0] r;
		r = w;
		r[lane*8 +: 8] = v;
		return r;
	endfunction

	always_ff @(posedge clk) begin
		if (state_q == StIdle && item_valid && !item.no_byte)
			blk_q[pos_q[5:2]] <= put(blk_q[pos_q[5:2]], pos_q[1:0], item.data_byte);
		else if (state_q == StPad) begin
			for (int w = 0; w < 16; w++)
				if (4'(w) == pos_q[5:2])
					blk_q[w] <= put(blk_q[w] & ((32'd1 << {pos_q[1:0], 3'b000}) - 32'd1),
						pos_q[1:0], md5_pkg::PadByte);
				else if (4'(w) > pos_q[5:2])
					blk_q[w] <= '0;
		end else if (state_q == StRound && round_q == 6'd63 && second_q) begin
			for (int w = 0; w < 16; w++) blk_q[w] <= '0;
		end else if (state_q == StLen) begin
			if (!second_q) begin
				blk_q[14] <= bits[31:0];
				blk_q[15] <= bits[63:32];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= StIdle;
			chain_q[0] <= md5_pkg::IvA; chain_q[1] <= md5_pkg::IvB;
			chain_q[2] <= md5_pkg::IvC; chain_q[3] <= md5_pkg::IvD;
			{a_q, b_q, c_q, d_q} <= '0;
			count_q <= '0; pos_q <= '0; round_q <= '0;
			fin_q <= 1'b0; second_q <= 1'b0;
		end else begin
			unique case (state_q)
				StIdle: if (item_valid) begin
					if (!item.no_byte) begin
						count_q <= count_q + 61'd1;
						pos_q <= pos_q + 6'd1;
					end
					fin_q <= 1'b0;
					if (!item.no_byte && pos_q == 6'd63) begin
						state_q <= StRound;
						{a_q, b_q, c_q, d_q} <= {chain_q[0], chain_q[1], chain_q[2], chain_q[3]};
					end else if (item.is_last) state_q <= StPad;
				end
				StPad: begin
					second_q <= (pos_q >= md5_pkg::LenPos);
					state_q <= StLen;
				end
				StLen: begin
					state_q <= StRound;
					fin_q <= !second_q;
					{a_q, b_q, c_q, d_q} <= {chain_q[0], chain_q[1], chain_q[2], chain_q[3]};
				end
				StRound: begin
					a_q <= d_q; d_q <= c_q; c_q <= b_q; b_q <= b_q + rot;
					round_q <= round_q + 6'd1;
					if (round_q == 6'd63) begin
						chain_q[0] <= chain_q[0] + d_q;
						chain_q[1] <= chain_q[1] + b_q + rot;
						chain_q[2] <= chain_q[2] + b_q;
						chain_q[3] <= chain_q[3] + c_q;
						if (fin_q) state_q <= StOut0;
						else if (second_q) begin
							second_q <= 1'b0;
							state_q <= StLen;
						end else if (pos_q == 6'd0 && item_pend_last_q) state_q <= StPad;
						else state_q <= StIdle;
					end
				end
				StOut0: if (pop) state_q <= StOut1;
				StOut1: if (pop) begin
					state_q <= StIdle;
					chain_q[0] <= md5_pkg::IvA; chain_q[1] <= md5_pkg::IvB;
					chain_q[2] <= md5_pkg::IvC; chain_q[3] <= md5_pkg::IvD;
					count_q <= '0; pos_q <= '0;
				end
				default: state_q <= StIdle;
			endcase
		end
	end

	// a full block that also carried the end flag still needs its padding block
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) item_pend_last_q <= 1'b0;
		else if (state_q == StIdle && item_valid)
			item_pend_last_q <= item.is_last && !item.no_byte && pos_q == 6'd63;
	end
endmodule
`default_nettype wire

>>> design/md5_digest_engine_top.sv
// md5_digest_engine_top: MD5 engine, input queue front and compression back end.
// Depends on md5_pkg, md5_queue, md5_core.
//
// channel | ports                              | handshake
// input   | data_byte, is_last, no_byte        | push / full
// result  | digest_part, part_last             | pop / empty
//
// The back end takes bytes only while idle, not while the single round unit compresses
// a block. A final item adds one block for padding and length, or two when the padding
// spills into a second block; setup runs through the StPad and StLen states.
// Reset empties the queue, sets the chaining words to the IV and clears the byte count.
// The queue lets input continue while the back end compresses or holds the digest for pop.
`timescale 1ns / 1ps
`default_nettype none
module md5_digest_engine_top #(
	parameter int LENGTH_FIELD_BITS = md5_pkg::LenBitsDefault
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire logic [7:0]  data_byte,
	input  wire logic        is_last,
	input  wire logic        no_byte,
	output logic             empty,
	input  wire logic        pop,
	output logic [63:0]      digest_part,
	output logic             part_last
);
	md5_pkg::item_t in_item, q_item;
	logic q_empty, take;

	assign in_item = '{data_byte: data_byte, is_last: is_last, no_byte: no_byte};

	md5_queue u_queue (
		.clk(clk), .arst_n(arst_n), .wr(push), .wdata(in_item), .full(full),
		.rd(take), .rdata(q_item), .empty(q_empty)
	);

	md5_core #(.LEN_BITS(LENGTH_FIELD_BITS)) u_core (
		.clk(clk), .arst_n(arst_n), .item(q_item), .item_valid(!q_empty),
		.item_take(take), .digest_part(digest_part), .part_last(part_last),
		.empty(empty), .pop(pop)
	);

`ifndef SYNTHESIS
	a_part_order: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !part_last && pop) |=> (!empty && part_last))
		else $error("second digest half missing");
	a_take_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		take |-> !q_empty)
		else $error("core took from empty queue");
	a_no_take_while_out: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> !take)
		else $error("item taken while digest pending");
`endif
endmodule
`default_nettype wire

>>> test/tb_md5_digest_engine_top.sv
// tb_md5_digest_engine_top: self-checking testbench for the MD5 digest engine.
// Drives byte streams through the push/full port, predicts digests in-bench, checks pop/empty.
// Depends on md5_pkg and md5_digest_engine_top.
`timescale 1ns / 1ps
`default_nettype none
module tb_md5_digest_engine_top;
	typedef struct {
		logic [63:0] digest_part;
		logic        part_last;
	} digest_half_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic [7:0]  data_byte = '0;
	logic        is_last = 1'b0;
	logic        no_byte = 1'b0;
	logic        pop = 1'b0;
	logic        full, empty;
	logic [63:0] digest_part;
	logic        part_last;

	md5_pkg::item_t pending_items[$];
	digest_half_t expected_halves[$];
	int           fail_count = 0;
	bit           stim_done = 1'b0;
	bit           quiet_tail = 1'b0;
	bit           hold_pop = 1'b0;
	int           push_gap = 0;
	int           pop_gap = 0;

	logic [31:0] hash_state[4];
	logic [31:0] msg_words[16];
	logic [60:0] msg_count;

	localparam logic [31:0] RoundK[64] = '{
		32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
		32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
		32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
		32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
		32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
		32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
		32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
		32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
		32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
		32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
		32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
		32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
		32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
		32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
		32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
		32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391};
	localparam int RotAmt[16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};

	md5_digest_engine_top u_dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full),
		.data_byte(data_byte), .is_last(is_last), .no_byte(no_byte),
		.empty(empty), .pop(pop), .digest_part(digest_part), .part_last(part_last)
	);

	always #1 clk = ~clk;

	function automatic logic [31:0] byte_rev(input logic [31:0] x);
		return {x[7:0], x[15:8], x[23:16], x[31:24]};
	endfunction

	task automatic place_byte(input int pos, input logic [7:0] b);
		msg_words[pos / 4][(pos % 4) * 8 +: 8] = b;
	endtask

	task automatic run_block();
		logic [31:0] a, b, c, d, f, t;
		int g;
		a = hash_state[0]; b = hash_state[1]; c = hash_state[2]; d = hash_state[3];
		for (int r = 0; r < 64; r++) begin
			if (r < 16) begin
				f = (b & c) | (~b & d); g = r;
			end else if (r < 32) begin
				f = (b & d) | (c & ~d); g = (5 * r + 1) % 16;
			end else if (r < 48) begin
				f = b ^ c ^ d; g = (3 * r + 5) % 16;
			end else begin
				f = c ^ (b | ~d); g = (7 * r) % 16;
			end
			t = f + a + RoundK[r] + msg_words[g];
			a = d; d = c; c = b;
			b = b + ((t << RotAmt[(r / 16) * 4 + r % 4]) | (t >> (32 - RotAmt[(r / 16) * 4 + r % 4])));
		end
		hash_state[0] += a; hash_state[1] += b; hash_state[2] += c; hash_state[3] += d;
	endtask

	task automatic reset_digest();
		hash_state[0] = md5_pkg::IvA; hash_state[1] = md5_pkg::IvB;
		hash_state[2] = md5_pkg::IvC; hash_state[3] = md5_pkg::IvD;
		msg_count = '0;
	endtask

	task automatic predict_digest(input md5_pkg::item_t it);
		int pos;
		logic [63:0] bit_len;
		digest_half_t h;
		if (!it.no_byte) begin
			pos = int'(msg_count[5:0]);
			place_byte(pos, it.data_byte);
			msg_count = msg_count + 1'b1;
			if (pos == 63) run_block();
		end
		if (!it.is_last) return;
		pos = int'(msg_count[5:0]);
		place_byte(pos, md5_pkg::PadByte);
		for (int i = pos + 1; i < 64; i++) place_byte(i, 8'h00);
		if (pos > 55) begin
			run_block();
			for (int i = 0; i < 16; i++) msg_words[i] = '0;
		end
		bit_len = {msg_count, 3'b000};
		msg_words[14] = bit_len[31:0];
		msg_words[15] = bit_len[63:32];
		run_block();
		h.digest_part = {byte_rev(hash_state[0]), byte_rev(hash_state[1])};
		h.part_last = 1'b0;
		expected_halves.push_back(h);
		h.digest_part = {byte_rev(hash_state[2]), byte_rev(hash_state[3])};
		h.part_last = 1'b1;
		expected_halves.push_back(h);
		reset_digest();
	endtask

	task automatic add_item(input logic [7:0] b, input logic l, input logic n);
		md5_pkg::item_t it;
		it.data_byte = b; it.is_last = l; it.no_byte = n;
		pending_items.push_back(it);
	endtask

	task automatic add_message(input int len);
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(0, 19) == 0) add_item(8'($urandom), 1'b0, 1'b1);
			add_item(8'($urandom), (i == len - 1), 1'b0);
		end
		if (len == 0) add_item(8'($urandom), 1'b1, 1'b1);
	endtask

	// driver
	always @(posedge clk) begin
		md5_pkg::item_t it;
		if (arst_n) begin
			if (push && !full) begin
				predict_digest(pending_items.pop_front());
			end
			if (push && full) begin
			end else if (push_gap > 0) begin
				push <= 1'b0;
				push_gap <= push_gap - 1;
			end else if (pending_items.size() > 0 && !(push && !full && pending_items.size() == 0)) begin
				if (!quiet_tail && $urandom_range(0, 7) == 0) begin
					push <= 1'b0;
					push_gap <= $urandom_range(1, 10);
				end else begin
					it = pending_items[0];
					push <= 1'b1;
					data_byte <= it.data_byte;
					is_last <= it.is_last;
					no_byte <= it.no_byte;
				end
			end else begin
				push <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		digest_half_t e;
		if (arst_n) begin
			if (pop && !empty) begin
				if (expected_halves.size() == 0) begin
					$error("unexpected result digest_part=%h part_last=%b", digest_part, part_last);
					fail_count++;
				end else begin
					e = expected_halves.pop_front();
					if (digest_part !== e.digest_part) begin
						$error("digest_part expected %h actual %h", e.digest_part, digest_part);
						fail_count++;
					end
					if (part_last !== e.part_last) begin
						$error("part_last expected %b actual %b", e.part_last, part_last);
						fail_count++;
					end
				end
			end
			if (hold_pop) begin
				pop <= 1'b0;
			end else if (pop_gap > 0) begin
				pop <= 1'b0;
				pop_gap <= pop_gap - 1;
			end else if (!quiet_tail && $urandom_range(0, 6) == 0) begin
				pop <= 1'b0;
				pop_gap <= $urandom_range(1, 10);
			end else begin
				pop <= 1'b1;
			end
		end
	end

	task automatic wait_drained();
		while (pending_items.size() > 0 || push || expected_halves.size() > 0) @(posedge clk);
	endtask

	initial begin
		reset_digest();
		for (int i = 0; i < 16; i++) msg_words[i] = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// directed: empty message, single bytes, trailing byte with end, idle items
		add_item(8'h00, 1'b1, 1'b1);
		add_item(8'hff, 1'b1, 1'b0);
		add_item(8'h00, 1'b1, 1'b0);
		add_item(8'h61, 1'b0, 1'b0);
		add_item(8'h5a, 1'b0, 1'b1);
		add_item(8'h62, 1'b0, 1'b0);
		add_item(8'h63, 1'b1, 1'b0);
		add_item(8'h41, 1'b0, 1'b0);
		add_item(8'h33, 1'b1, 1'b1);
		add_item(8'haa, 1'b0, 1'b1);
		wait_drained();

		// lengths around padding overflow and block boundaries
		add_message(55);
		add_message(56);
		add_message(63);
		add_message(64);
		wait_drained();

		// long receiver hold-off while the sender keeps pushing
		hold_pop = 1'b1;
		add_message(3);
		add_message(0);
		add_message(5);
		add_message(1);
		add_message(2);
		repeat (600) @(posedge clk);
		hold_pop = 1'b0;
		wait_drained();

		for (int m = 0; m < 12; m++) begin
			if ($urandom_range(0, 9) == 0) add_message($urandom_range(50, 70));
			else add_message($urandom_range(0, 12));
			if (m == 8) begin
				wait_drained();
				quiet_tail = 1'b1;
			end
		end
		wait_drained();
		stim_done = 1'b1;
		repeat (300) @(posedge clk);
		if (fail_count == 0 && expected_halves.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("CHECKS FAILED");
		$finish;
	end
endmodule
`default_nettype wire
